// File: hw/rtl/thermistor_resistance_to_temperature_defines.svh
// Assertion macros used by the checker file.
`ifndef THERMISTOR_RESISTANCE_TO_TEMPERATURE_DEFINES_SVH
`define THERMISTOR_RESISTANCE_TO_TEMPERATURE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRT_ASSERT_SAME(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TRT_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// File: hw/rtl/trt_pkg.sv
package trt_pkg;

  localparam int RES_W = 20;
  localparam int TEMP_W = 12;
  localparam int TABLE_POINTS = 10;
  localparam int SEG_W = $clog2(TABLE_POINTS);
  localparam int DT_W = TEMP_W + 1;
  localparam int PROD_W = RES_W + 1 + DT_W;
  localparam int NUM_W = PROD_W + 2;
  localparam int Q_W = 12;
  localparam int DIV_BPS = 2;
  localparam int DIV_STAGES = Q_W / DIV_BPS;
  localparam int TEMP_MIN = -1024;
  localparam int TEMP_MAX = 2047;

  localparam logic [RES_W-1:0] CURVE_OHMS [TABLE_POINTS] = '{
    20'd332776, 20'd96481, 20'd32566, 20'd12486, 20'd10000,
    20'd5331, 20'd2490, 20'd1071, 20'd678, 20'd338
  };

  localparam logic signed [TEMP_W-1:0] CURVE_TENTHS [TABLE_POINTS] = '{
    -12'sd400, -12'sd200, 12'sd0, 12'sd200, 12'sd250,
    12'sd400, 12'sd600, 12'sd850, 12'sd1000, 12'sd1200
  };

  typedef struct packed {
    logic neg;
    logic ovf;
    logic above;
    logic below;
  } side_t;

  function automatic logic [RES_W-1:0] seg_r2(input logic [SEG_W-1:0] seg);
    return CURVE_OHMS[seg];
  endfunction

  function automatic logic [RES_W-1:0] seg_den(input logic [SEG_W-1:0] seg);
    return CURVE_OHMS[seg - 1'b1] - CURVE_OHMS[seg];
  endfunction

  function automatic logic signed [DT_W-1:0] seg_dt(input logic [SEG_W-1:0] seg);
    logic signed [DT_W-1:0] t1;
    logic signed [DT_W-1:0] t2;
    t1 = DT_W'(CURVE_TENTHS[seg - 1'b1]);
    t2 = DT_W'(CURVE_TENTHS[seg]);
    return t1 - t2;
  endfunction

  function automatic logic signed [NUM_W-1:0] seg_base(input logic [SEG_W-1:0] seg);
    logic signed [NUM_W-1:0] t2;
    logic signed [NUM_W-1:0] den;
    t2 = NUM_W'(CURVE_TENTHS[seg]);
    den = NUM_W'(signed'({1'b0, seg_den(seg)}));
    return NUM_W'(t2 * den);
  endfunction

endpackage

// File: hw/rtl/trt_div.sv
module trt_div
  import trt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [NUM_W-1:0] in_mag,
  input  logic [RES_W-1:0] in_den,
  input  side_t            in_side,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [Q_W-1:0]   out_quo,
  output side_t            out_side
);

  logic             v_r    [DIV_STAGES];
  logic [NUM_W-1:0] rem_r  [DIV_STAGES];
  logic [RES_W-1:0] den_r  [DIV_STAGES];
  logic [Q_W-1:0]   quo_r  [DIV_STAGES];
  side_t            side_r [DIV_STAGES];

  logic             v_a    [DIV_STAGES+1];
  logic [NUM_W-1:0] rem_a  [DIV_STAGES+1];
  logic [RES_W-1:0] den_a  [DIV_STAGES+1];
  logic [Q_W-1:0]   quo_a  [DIV_STAGES+1];
  side_t            side_a [DIV_STAGES+1];
  logic             rdy    [DIV_STAGES+1];

  logic [NUM_W-1:0] rem_nxt [DIV_STAGES];
  logic [Q_W-1:0]   quo_nxt [DIV_STAGES];

  always_comb begin
    v_a[0] = in_valid;
    rem_a[0] = in_mag;
    den_a[0] = in_den;
    quo_a[0] = '0;
    side_a[0] = in_side;
    for (int s = 0; s < DIV_STAGES; s++) begin
      v_a[s+1] = v_r[s];
      rem_a[s+1] = rem_r[s];
      den_a[s+1] = den_r[s];
      quo_a[s+1] = quo_r[s];
      side_a[s+1] = side_r[s];
    end
  end

  always_comb begin
    rdy[DIV_STAGES] = out_ready;
    for (int s = DIV_STAGES - 1; s >= 0; s--) begin
      rdy[s] = !v_r[s] || rdy[s+1];
    end
  end

  always_comb begin
    logic [NUM_W-1:0] rem;
    logic [NUM_W-1:0] sh;
    logic [Q_W-1:0]   quo;
    logic             bit_q;
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem = rem_a[s];
      quo = quo_a[s];
      for (int j = 0; j < DIV_BPS; j++) begin
        sh = NUM_W'(den_a[s]) << (Q_W - 1 - s * DIV_BPS - j);
        bit_q = (rem >= sh);
        if (bit_q) begin
          rem = rem - sh;
        end
        quo = {quo[Q_W-2:0], bit_q};
      end
      rem_nxt[s] = rem;
      quo_nxt[s] = quo;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= v_a[s];
      end
      if (rdy[s] && v_a[s]) begin
        rem_r[s] <= rem_nxt[s];
        quo_r[s] <= quo_nxt[s];
        den_r[s] <= den_a[s];
        side_r[s] <= side_a[s];
      end
    end
  end

  assign in_ready = rdy[0];
  assign out_valid = v_r[DIV_STAGES-1];
  assign out_quo = quo_r[DIV_STAGES-1];
  assign out_side = side_r[DIV_STAGES-1];

endmodule

// File: hw/rtl/thermistor_resistance_to_temperature.sv
// Stages: an accepted item passes in order through segment search, multiply, sum and
// sign, six divider stages of two quotient bits, and output saturation.
// Throughput: one item per cycle; each stage advances whenever the stage after it is
// empty or moving, so a stall only holds items in place.
// Reset: synchronous active-low rst_n clears every stage valid bit; data is not reset.
module thermistor_resistance_to_temperature
  import trt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [RES_W-1:0]         in_resistance_ohms,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [TEMP_W-1:0] out_temp_tenths,
  output logic                     out_above_table,
  output logic                     out_below_table
);

  logic             s1_v_r;
  logic [RES_W-1:0] s1_res_r;
  logic [SEG_W-1:0] s1_seg_r;
  logic             s1_above_r;
  logic             s1_below_r;

  logic                     s2_v_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  logic signed [NUM_W-1:0]  s2_base_r;
  logic [RES_W-1:0]         s2_den_r;
  logic                     s2_above_r;
  logic                     s2_below_r;

  logic             s3_v_r;
  logic [NUM_W-1:0] s3_mag_r;
  logic [RES_W-1:0] s3_den_r;
  side_t            s3_side_r;

  logic                     out_valid_r;
  logic signed [TEMP_W-1:0] out_temp_r;
  logic                     out_above_r;
  logic                     out_below_r;

  logic rdy1, rdy2, rdy3, rdy_o, div_in_ready;
  logic div_valid;
  logic [Q_W-1:0] div_quo;
  side_t div_side;

  logic [SEG_W-1:0] seg_nxt;
  logic             hit_nxt;
  logic             above_nxt;

  logic [RES_W-1:0]         diff;
  logic signed [PROD_W-1:0] prod_nxt;

  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        mag_nxt;
  logic                    ovf_nxt;

  logic signed [Q_W:0]      quo_s;
  logic signed [Q_W:0]      neg_q;
  logic signed [TEMP_W-1:0] temp_nxt;

  assign rdy_o = !out_valid_r || out_ready;
  assign rdy3 = !s3_v_r || div_in_ready;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    hit_nxt = 1'b0;
    seg_nxt = SEG_W'(1);
    for (int i = 1; i < TABLE_POINTS; i++) begin
      if (!hit_nxt && (in_resistance_ohms >= CURVE_OHMS[i])) begin
        hit_nxt = 1'b1;
        seg_nxt = SEG_W'(i);
      end
    end
    above_nxt = in_resistance_ohms > CURVE_OHMS[0];
  end

  always_comb begin
    diff = s1_res_r - seg_r2(s1_seg_r);
    prod_nxt = signed'({1'b0, diff}) * seg_dt(s1_seg_r);
  end

  always_comb begin
    num = NUM_W'(s2_prod_r) + s2_base_r;
    mag_nxt = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    ovf_nxt = mag_nxt >= (NUM_W'(s2_den_r) << Q_W);
  end

  always_comb begin
    quo_s = signed'({1'b0, div_quo});
    neg_q = -quo_s;
    if (div_side.below) begin
      temp_nxt = CURVE_TENTHS[TABLE_POINTS-1];
    end else if (div_side.neg) begin
      if (div_side.ovf || (quo_s > (Q_W+1)'(-TEMP_MIN))) begin
        temp_nxt = TEMP_W'(TEMP_MIN);
      end else begin
        temp_nxt = neg_q[TEMP_W-1:0];
      end
    end else begin
      if (div_side.ovf || (quo_s > (Q_W+1)'(TEMP_MAX))) begin
        temp_nxt = TEMP_W'(TEMP_MAX);
      end else begin
        temp_nxt = quo_s[TEMP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_v_r <= in_valid;
      end
      if (rdy2) begin
        s2_v_r <= s1_v_r;
      end
      if (rdy3) begin
        s3_v_r <= s2_v_r;
      end
      if (rdy_o) begin
        out_valid_r <= div_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_res_r <= in_resistance_ohms;
      s1_seg_r <= seg_nxt;
      s1_above_r <= above_nxt;
      s1_below_r <= !hit_nxt;
    end
    if (rdy2 && s1_v_r) begin
      s2_prod_r <= prod_nxt;
      s2_base_r <= seg_base(s1_seg_r);
      s2_den_r <= seg_den(s1_seg_r);
      s2_above_r <= s1_above_r;
      s2_below_r <= s1_below_r;
    end
    if (rdy3 && s2_v_r) begin
      s3_mag_r <= mag_nxt;
      s3_den_r <= s2_den_r;
      s3_side_r.neg <= num[NUM_W-1];
      s3_side_r.ovf <= ovf_nxt;
      s3_side_r.above <= s2_above_r;
      s3_side_r.below <= s2_below_r;
    end
    if (rdy_o && div_valid) begin
      out_temp_r <= temp_nxt;
      out_above_r <= div_side.above;
      out_below_r <= div_side.below;
    end
  end

  trt_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_v_r),
    .in_ready  (div_in_ready),
    .in_mag    (s3_mag_r),
    .in_den    (s3_den_r),
    .in_side   (s3_side_r),
    .out_valid (div_valid),
    .out_ready (rdy_o),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  assign out_valid = out_valid_r;
  assign out_temp_tenths = out_temp_r;
  assign out_above_table = out_above_r;
  assign out_below_table = out_below_r;

endmodule

// File: hw/rtl/trt_checker.sv
`include "thermistor_resistance_to_temperature_defines.svh"

module trt_checker
  import trt_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [RES_W-1:0]         in_resistance_ohms,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [TEMP_W-1:0] out_temp_tenths,
  input logic                     out_above_table,
  input logic                     out_below_table
);

  `TRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_temp_tenths), "result item dropped or changed while stalled")
  `TRT_ASSERT_SAME(a_flags_exclusive, out_valid, !(out_above_table && out_below_table), "result item flagged both above and below the table")
  `TRT_ASSERT_SAME(a_below_clamp, out_valid && out_below_table, out_temp_tenths == CURVE_TENTHS[TABLE_POINTS-1], "clamped result item does not hold the last table temperature")
  `TRT_ASSERT_SAME(a_above_extrap, out_valid && out_above_table, out_temp_tenths <= CURVE_TENTHS[0], "extrapolated result item is warmer than the first table point")

endmodule

bind thermistor_resistance_to_temperature trt_checker u_trt_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .in_resistance_ohms (in_resistance_ohms),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_temp_tenths    (out_temp_tenths),
  .out_above_table    (out_above_table),
  .out_below_table    (out_below_table)
);
